[sv/tht_pkg.sv]
package tht_pkg;

    // Field widths
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned HANDLE_W = 10;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 3;

    // Allocation bounds and register reset
    localparam logic [HANDLE_W-1:0] HANDLE_LIMIT = 10'd1023;
    localparam logic [HANDLE_W-1:0] THRESH_RESET = 10'd992;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_ALLOC      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_READ_PROP  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_READ_BLOCK = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEL_PROP   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEL_BLOCK  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_REPAIR     = 3'd5;
    localparam logic [MODE_W-1:0] MODE_READ_TYPE  = 3'd6;

    // Kind tags
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BLOCK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PROP  = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_CORRUPT  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_DELETED  = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_WRONG    = 3'd5;
    localparam logic [STATUS_W-1:0] STAT_MISMATCH = 3'd6;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [HANDLE_W-1:0] handle;
        logic [KIND_W-1:0]   kind;
        logic [VALUE_W-1:0]  object_value;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] result_handle;
        logic [VALUE_W-1:0]  result_value;
        logic [KIND_W-1:0]   result_kind;
        logic [HANDLE_W-1:0] handles_used;
    } t_out;

    // Outcome of a checked access, from the checker to the sequencer
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  rd_value;
        logic [KIND_W-1:0]   rd_kind;
        logic                wr_en;
        logic [VALUE_W-1:0]  wr_value;
        logic [KIND_W-1:0]   wr_kind;
    } t_chk;

endpackage

[sv/tht_ram.sv]
module tht_ram #(
    parameter int unsigned WIDTH = 34,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, one registered read port; read data holds while idle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/tht_check.sv]
module tht_check (
    input  tht_pkg::t_in                    i_op,
    input  logic [tht_pkg::HANDLE_W-1:0]    i_count,
    input  logic                            i_mem_ok,
    input  logic [tht_pkg::VALUE_W-1:0]     i_mem_value,
    input  logic [tht_pkg::KIND_W-1:0]      i_mem_kind,
    output tht_pkg::t_chk                   o_chk
);
    import tht_pkg::*;

    logic [VALUE_W-1:0] value;
    logic [KIND_W-1:0]  kind;
    logic [KIND_W-1:0]  want;
    logic               out_of_range;
    logic               kind_ok;

    // Entry contents; an entry never written or beyond the table is empty
    assign value        = i_mem_ok ? i_mem_value : '0;
    assign kind         = i_mem_ok ? i_mem_kind : KIND_NONE;
    assign out_of_range = i_op.handle > i_count;
    assign kind_ok      = (kind == KIND_BLOCK) || (kind == KIND_PROP);
    assign want         = ((i_op.mode == MODE_READ_PROP) || (i_op.mode == MODE_DEL_PROP))
                          ? KIND_PROP : KIND_BLOCK;

    // Status, returned data and write-back for one access
    always_comb begin
        o_chk = '0;
        o_chk.status = STAT_OK;
        case (i_op.mode) inside
            MODE_READ_PROP, MODE_READ_BLOCK, MODE_DEL_PROP, MODE_DEL_BLOCK,
            MODE_READ_TYPE: begin
                if (out_of_range) begin
                    o_chk.status = STAT_RANGE;
                end else if (!kind_ok) begin
                    o_chk.status = STAT_CORRUPT;
                end else if (i_op.mode == MODE_READ_TYPE) begin
                    o_chk.rd_kind = kind;
                end else if (value == '0) begin
                    o_chk.status = STAT_DELETED;
                end else if (kind != want) begin
                    o_chk.status = STAT_WRONG;
                end else if ((i_op.mode == MODE_READ_PROP) ||
                             (i_op.mode == MODE_READ_BLOCK)) begin
                    o_chk.rd_value = value;
                end else begin
                    // delete clears value and kind
                    o_chk.wr_en = 1'b1;
                end
            end
            MODE_REPAIR: begin
                if (out_of_range) begin
                    o_chk.status = STAT_RANGE;
                end else if (value == '0) begin
                    o_chk.wr_en    = 1'b1;
                    o_chk.wr_value = i_op.object_value;
                    o_chk.wr_kind  = i_op.kind;
                end else if ((value != i_op.object_value) || (kind != i_op.kind)) begin
                    o_chk.status = STAT_MISMATCH;
                end
            end
            default: begin
                o_chk.status = STAT_OK;
            end
        endcase
    end

endmodule

[sv/typed_handle_table_core.sv]
// Typed handle table. Each entry holds a 32-bit object value and a 2-bit
// kind tag in one single-port-read synchronous RAM; a value of zero marks
// an empty entry. Read, delete, repair and read type first read the RAM,
// then check the entry, write it back and register the result; a plain
// allocate writes the new entry and registers the result. An allocate
// issued once the used count is above reuse_threshold scans downward
// from count-1 for an empty entry, one RAM read per cycle, examining at
// most count - 1 entries. One item is in flight at a time; the next one is
// taken as soon as the previous result sits in the output register. No
// clearing pass is needed after reset: entries above the used count are
// never read, and handle 0 carries its own valid flag. The reuse threshold
// is written through the configuration port, which is always ready.
module typed_handle_table_core #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    input  tht_pkg::t_in                      i_in,
    output logic                              o_in_stall,
    // output channel
    output logic                              o_out_valid,
    output tht_pkg::t_out                     o_out,
    input  logic                              i_out_stall,
    // configuration write
    input  logic                              i_cfg_valid,
    input  logic [tht_pkg::HANDLE_W-1:0]      i_cfg_data,
    output logic                              o_cfg_ready
);
    import tht_pkg::*;

    localparam int unsigned AW    = $clog2(TABLE_DEPTH);
    localparam int unsigned RAM_W = VALUE_W + KIND_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_ALLOC
    } t_state;

    t_state              r_state, n_state;
    t_in                 r_in, n_in;
    logic [HANDLE_W-1:0] r_count, n_count;
    logic [HANDLE_W-1:0] r_thresh;
    logic                r_zero_valid, n_zero_valid;
    logic                r_out_valid, n_out_valid;
    t_out                r_out, n_out;
    logic [HANDLE_W-1:0] r_got, n_got;
    logic                r_full, n_full;
    logic [HANDLE_W-1:0] r_scan_idx, n_scan_idx;
    logic                r_issue_on, n_issue_on;
    logic                r_chk_on, n_chk_on;
    logic [HANDLE_W-1:0] r_chk_idx, n_chk_idx;

    logic                accept;
    logic                slot_free;
    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [RAM_W-1:0]    ram_wr_data;
    logic                ram_rd_en;
    logic [AW-1:0]       ram_rd_addr;
    logic [RAM_W-1:0]    ram_rd_data;
    logic [VALUE_W-1:0]  mem_value;
    logic [KIND_W-1:0]   mem_kind;
    logic                mem_ok;
    logic                chk_empty;
    t_chk                chk;

    // RAM address of a handle
    function automatic logic [AW-1:0] addr_of(input logic [HANDLE_W-1:0] h);
        logic [31:0] h_ext;
        h_ext = 32'(h);
        return h_ext[AW-1:0];
    endfunction

    // Handle lies inside the table
    function automatic logic in_table(input logic [HANDLE_W-1:0] h);
        return 32'(h) < TABLE_DEPTH;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign mem_value = ram_rd_data[VALUE_W-1:0];
    assign mem_kind  = ram_rd_data[RAM_W-1:VALUE_W];

    // Entry state RAM: {kind, value}
    tht_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Entry checker for the held transaction
    assign mem_ok = in_table(r_in.handle) && ((r_in.handle != '0) || r_zero_valid);

    tht_check u_check (
        .i_op        (r_in),
        .i_count     (r_count),
        .i_mem_ok    (mem_ok),
        .i_mem_value (mem_value),
        .i_mem_kind  (mem_kind),
        .o_chk       (chk)
    );

    // Scanned entry is free (scan never reaches handle 0)
    assign chk_empty = !in_table(r_chk_idx) || (mem_value == '0);

    // RAM read port
    always_comb begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = addr_of(i_in.handle);
        if (r_state == S_SCAN) begin
            ram_rd_en   = r_issue_on;
            ram_rd_addr = addr_of(r_scan_idx);
        end else if (accept) begin
            ram_rd_en = 1'b1;
        end
    end

    // RAM write port
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = addr_of(r_in.handle);
        ram_wr_data = {chk.wr_kind, chk.wr_value};
        if (r_state == S_ALLOC) begin
            ram_wr_en   = slot_free && !r_full && in_table(r_got);
            ram_wr_addr = addr_of(r_got);
            ram_wr_data = {r_in.kind, r_in.object_value};
        end else if (r_state == S_EXEC) begin
            ram_wr_en = slot_free && chk.wr_en && in_table(r_in.handle);
        end
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_in         = r_in;
        n_count      = r_count;
        n_zero_valid = r_zero_valid;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_got        = r_got;
        n_full       = r_full;
        n_scan_idx   = r_scan_idx;
        n_issue_on   = r_issue_on;
        n_chk_on     = r_chk_on;
        n_chk_idx    = r_chk_idx;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_in = i_in;
                    if (i_in.mode != MODE_ALLOC) begin
                        n_state = S_EXEC;
                    end else if (r_count >= HANDLE_LIMIT) begin
                        n_full  = 1'b1;
                        n_got   = '0;
                        n_state = S_ALLOC;
                    end else if ((r_count > r_thresh) && (r_count >= HANDLE_W'(2))) begin
                        n_scan_idx = r_count - HANDLE_W'(1);
                        n_issue_on = 1'b1;
                        n_chk_on   = 1'b0;
                        n_state    = S_SCAN;
                    end else begin
                        n_got   = r_count + HANDLE_W'(1);
                        n_full  = (r_count + HANDLE_W'(1)) >= HANDLE_LIMIT;
                        n_state = S_ALLOC;
                    end
                end
            end
            S_EXEC: begin
                if (slot_free) begin
                    n_out_valid              = 1'b1;
                    n_out.status             = chk.status;
                    n_out.result_handle      = '0;
                    n_out.result_value       = chk.rd_value;
                    n_out.result_kind        = chk.rd_kind;
                    n_out.handles_used       = r_count;
                    if (ram_wr_en && (r_in.handle == '0)) begin
                        n_zero_valid = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                // one read issued and one entry checked per cycle
                n_chk_on  = r_issue_on;
                n_chk_idx = r_scan_idx;
                if (r_issue_on) begin
                    if (r_scan_idx == HANDLE_W'(1)) begin
                        n_issue_on = 1'b0;
                    end else begin
                        n_scan_idx = r_scan_idx - HANDLE_W'(1);
                    end
                end
                if (r_chk_on && chk_empty) begin
                    n_got   = r_chk_idx;
                    n_full  = 1'b0;
                    n_state = S_ALLOC;
                end else if (r_chk_on && !r_issue_on) begin
                    // nothing free below the count
                    n_got   = r_count + HANDLE_W'(1);
                    n_full  = (r_count + HANDLE_W'(1)) >= HANDLE_LIMIT;
                    n_state = S_ALLOC;
                end
            end
            S_ALLOC: begin
                if (slot_free) begin
                    n_out_valid         = 1'b1;
                    n_out.result_value  = '0;
                    n_out.result_kind   = KIND_NONE;
                    if (r_full) begin
                        n_out.status        = STAT_FULL;
                        n_out.result_handle = '0;
                        n_out.handles_used  = r_count;
                    end else begin
                        n_out.status        = STAT_OK;
                        n_out.result_handle = r_got;
                        if (r_got >= r_count) begin
                            n_count = r_count + HANDLE_W'(1);
                        end
                        n_out.handles_used  = (r_got >= r_count) ? r_count + HANDLE_W'(1)
                                                                 : r_count;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_thresh     <= THRESH_RESET;
            r_zero_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_issue_on   <= 1'b0;
            r_chk_on     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_zero_valid <= n_zero_valid;
            r_out_valid  <= n_out_valid;
            r_issue_on   <= n_issue_on;
            r_chk_on     <= n_chk_on;
            if (i_cfg_valid) begin
                r_thresh <= i_cfg_data;
            end
        end
        r_in       <= n_in;
        r_out      <= n_out;
        r_got      <= n_got;
        r_full     <= n_full;
        r_scan_idx <= n_scan_idx;
        r_chk_idx  <= n_chk_idx;
    end

`ifndef NO_ASSERTIONS
    // The used count stays below the handle limit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < HANDLE_LIMIT)
        else $error("used count reached the handle limit");

    // The used count never falls
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_count >= $past(r_count)))
        else $error("used count decreased");

    // The RAM is written only when a transaction completes
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_wr_en |-> (slot_free && ((r_state == S_EXEC) || (r_state == S_ALLOC))))
        else $error("RAM write outside completion");

    // A granted handle is nonzero and within the used count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC && slot_free && !r_full) |=>
            (r_out.result_handle != '0) && (r_out.result_handle <= r_count))
        else $error("allocated handle out of range");
`endif

endmodule
